### rtl/core/spk_arb_pkg.sv
// ----------------------------------------------------------------------------
// spk_arb_pkg
// Shared types and codes for the speaker source arbiter.
// ----------------------------------------------------------------------------
package spk_arb_pkg;

    localparam int unsigned GEN_W    = 32;
    localparam int unsigned TIME_W   = 48;
    localparam int unsigned BUDGET_W = 20;
    localparam int unsigned DL_W     = TIME_W + 1;

    localparam logic [BUDGET_W-1:0] BUDGET_RESET = 20'd3000;

    typedef enum logic [1:0] {
        REQ_BEGIN_SESSION = 2'd0,
        REQ_PLAYBACK      = 2'd1,
        REQ_FINISHED      = 2'd2,
        REQ_TICK          = 2'd3
    } t_req_type;

    typedef enum logic [1:0] {
        SRC_CRITICAL  = 2'd0,
        SRC_REMINDER  = 2'd1,
        SRC_CLOUD     = 2'd2,
        SRC_PROACTIVE = 2'd3
    } t_source;

    typedef enum logic [1:0] {
        VERDICT_DENIED   = 2'd0,
        VERDICT_GRANTED  = 2'd1,
        VERDICT_DEFERRED = 2'd2,
        VERDICT_NONE     = 2'd3
    } t_verdict;

endpackage

### rtl/core/speaker_source_arbiter.sv
// Pipeline: a request is captured in the input register, and its result in the result
//   register. Throughput: one request per cycle while the result channel is not stalled.
//   The state update for a request is combinational between the input and result registers.
// Reset: synchronous, active low. Arbitration state clears, the budget returns to
//   3000 ms, and both pipeline registers come up empty.
// ----------------------------------------------------------------------------
// speaker_source_arbiter
// Arbitrates one speaker among four audio sources, with a deferred local
// reminder that is started on finish or forced on a deadline tick.
// ----------------------------------------------------------------------------
module speaker_source_arbiter
    import spk_arb_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration: reminder budget in ms
    input  logic                i_cfg_we,
    input  logic [BUDGET_W-1:0] i_cfg_wdata,
    // request channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [1:0]          i_req_type,
    input  logic [GEN_W-1:0]    i_generation,
    input  logic [1:0]          i_source,
    input  logic [TIME_W-1:0]   i_now_ms,
    // result channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [1:0]          o_verdict,
    output logic                o_reminder_started,
    output logic                o_speaker_busy,
    output logic [1:0]          o_active_source,
    output logic                o_normal_was_preempted
);

    // Configuration register
    logic [BUDGET_W-1:0] r_budget;

    // Input register
    logic                r_in_valid;
    t_req_type           r_req_type;
    logic [GEN_W-1:0]    r_generation;
    t_source             r_source;
    logic [TIME_W-1:0]   r_now_ms;

    // Arbitration state
    logic [GEN_W-1:0]    r_live_gen;
    logic                r_busy;
    t_source             r_holder;
    logic                r_preempt;
    logic                r_rem_pending;
    logic [DL_W-1:0]     r_rem_deadline;

    logic [GEN_W-1:0]    n_live_gen;
    logic                n_busy;
    t_source             n_holder;
    logic                n_preempt;
    logic                n_rem_pending;
    logic [DL_W-1:0]     n_rem_deadline;
    t_verdict            n_verdict;
    logic                n_started;

    // Result register
    logic                r_out_valid;
    t_verdict            r_verdict;
    logic                r_started;
    logic                r_out_busy;
    t_source             r_out_source;
    logic                r_out_preempt;

    logic                advance;
    logic                in_take;
    logic [DL_W-1:0]     now_ext;
    logic [DL_W-1:0]     deadline_sum;
    logic                in_budget;

    // The stage moves whenever the result register is free or being drained.
    assign advance    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    assign now_ext      = {1'b0, r_now_ms};
    assign deadline_sum = now_ext + {{(DL_W-BUDGET_W){1'b0}}, r_budget};
    assign in_budget    = now_ext <= r_rem_deadline;

    // Next arbitration state and verdict for the request in the input register
    always_comb begin
        n_live_gen     = r_live_gen;
        n_busy         = r_busy;
        n_holder       = r_holder;
        n_preempt      = r_preempt;
        n_rem_pending  = r_rem_pending;
        n_rem_deadline = r_rem_deadline;
        n_verdict      = VERDICT_NONE;
        n_started      = 1'b0;
        case (r_req_type)
            REQ_BEGIN_SESSION: begin
                // new session: drop all playback state, keep the stored holder
                n_live_gen     = r_generation;
                n_busy         = 1'b0;
                n_preempt      = 1'b0;
                n_rem_pending  = 1'b0;
                n_rem_deadline = '0;
            end
            REQ_PLAYBACK: begin
                if (r_generation != r_live_gen) begin
                    n_verdict = VERDICT_DENIED;
                end else if (r_source == SRC_CRITICAL) begin
                    // a current-generation critical request always wins; mark a displaced normal source
                    if (r_busy && r_holder != SRC_CRITICAL) begin
                        n_preempt = 1'b1;
                    end
                    n_busy    = 1'b1;
                    n_holder  = SRC_CRITICAL;
                    n_verdict = VERDICT_GRANTED;
                end else if (!r_busy) begin
                    n_busy    = 1'b1;
                    n_holder  = r_source;
                    n_verdict = VERDICT_GRANTED;
                end else begin
                    // hold one reminder behind a normal source, drop the rest
                    if (r_source == SRC_REMINDER && r_holder != SRC_CRITICAL &&
                        !r_rem_pending) begin
                        n_rem_pending  = 1'b1;
                        n_rem_deadline = deadline_sum;
                    end
                    n_verdict = VERDICT_DEFERRED;
                end
            end
            REQ_FINISHED: begin
                n_busy    = 1'b0;
                n_preempt = 1'b0;
                if (r_rem_pending && in_budget) begin
                    n_rem_pending  = 1'b0;
                    n_rem_deadline = '0;
                    n_busy         = 1'b1;
                    n_holder       = SRC_REMINDER;
                    n_started      = 1'b1;
                end
            end
            REQ_TICK: begin
                // deadline passed: seize the speaker for the held reminder
                if (r_rem_pending && !in_budget) begin
                    n_rem_pending  = 1'b0;
                    n_rem_deadline = '0;
                    n_busy         = 1'b1;
                    n_holder       = SRC_REMINDER;
                    n_preempt      = 1'b0;
                    n_started      = 1'b1;
                end
            end
            default: begin
                n_verdict = VERDICT_NONE;
            end
        endcase
    end

    // Control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_budget       <= BUDGET_RESET;
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_live_gen     <= '0;
            r_busy         <= 1'b0;
            r_holder       <= SRC_CRITICAL;
            r_preempt      <= 1'b0;
            r_rem_pending  <= 1'b0;
            r_rem_deadline <= '0;
        end else begin
            if (i_cfg_we) begin
                r_budget <= i_cfg_wdata;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            // an empty input register takes a request even while the result is held
            if (advance || !r_in_valid) begin
                r_in_valid <= in_take;
            end
            if (advance && r_in_valid) begin
                r_live_gen     <= n_live_gen;
                r_busy         <= n_busy;
                r_holder       <= n_holder;
                r_preempt      <= n_preempt;
                r_rem_pending  <= n_rem_pending;
                r_rem_deadline <= n_rem_deadline;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_req_type   <= t_req_type'(i_req_type);
            r_generation <= i_generation;
            r_source     <= t_source'(i_source);
            r_now_ms     <= i_now_ms;
        end
        if (advance && r_in_valid) begin
            r_verdict     <= n_verdict;
            r_started     <= n_started;
            r_out_busy    <= n_busy;
            r_out_source  <= n_busy ? n_holder : SRC_CRITICAL;
            r_out_preempt <= n_preempt;
        end
    end

    assign o_out_valid            = r_out_valid;
    assign o_verdict              = r_verdict;
    assign o_reminder_started     = r_started;
    assign o_speaker_busy         = r_out_busy;
    assign o_active_source        = r_out_source;
    assign o_normal_was_preempted = r_out_preempt;

endmodule

### rtl/core/spk_arb_checker.sv
// ----------------------------------------------------------------------------
// spk_arb_checker
// Port-level checks for the speaker source arbiter, bound to the top level.
// ----------------------------------------------------------------------------
module spk_arb_checker
    import spk_arb_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [1:0] o_verdict,
    input logic       o_reminder_started,
    input logic       o_speaker_busy,
    input logic [1:0] o_active_source,
    input logic       o_normal_was_preempted
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_verdict) &&
        $stable(o_speaker_busy) && $stable(o_active_source))
        else $error("stalled result changed");

    a_idle_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_speaker_busy |-> o_active_source == SRC_CRITICAL)
        else $error("idle speaker reports a source");

    a_rem_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_reminder_started |->
        o_verdict == VERDICT_NONE && o_speaker_busy && o_active_source == SRC_REMINDER)
        else $error("reminder start inconsistent");

    a_preempt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_normal_was_preempted |->
        o_speaker_busy && o_active_source == SRC_CRITICAL)
        else $error("preempt mark without critical holder");

    a_deferred_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_verdict == VERDICT_DEFERRED |-> o_speaker_busy)
        else $error("deferred while idle");

endmodule

bind speaker_source_arbiter spk_arb_checker u_spk_arb_checker (
    .i_clk                  (i_clk),
    .i_rst_n                (i_rst_n),
    .o_out_valid            (o_out_valid),
    .i_out_stall            (i_out_stall),
    .o_verdict              (o_verdict),
    .o_reminder_started     (o_reminder_started),
    .o_speaker_busy         (o_speaker_busy),
    .o_active_source        (o_active_source),
    .o_normal_was_preempted (o_normal_was_preempted)
);
